// File: rtl/core/asp_pkg.sv
// Shared constants, divisor tables and the easing table generator for the arm swing block.
`timescale 1ns / 1ps

package asp_pkg;

  // Default sizing handed to the top level
  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int ANGLE_WIDTH_DEF      = 16;

  // Configuration register map
  localparam int          CFG_IDX_W       = 3;
  localparam int          CFG_W           = 48;
  localparam logic [2:0]  REG_LEFT_START  = 3'd0;
  localparam logic [2:0]  REG_LEFT_END    = 3'd1;
  localparam logic [2:0]  REG_RIGHT_START = 3'd2;
  localparam logic [2:0]  REG_RIGHT_END   = 3'd3;

  // Result sequencing
  localparam int          NUM_JOINTS  = 6;
  localparam logic [2:0]  JOINT_LAST  = 3'd5;

  // Q30 trig constants
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Q3.12 angle constants
  localparam int PI_Q12     = 12868;
  localparam int TWO_PI_Q12 = 25736;
  localparam int MIN_ROLL   = 357;

  // Lateral margin: (ex * 858 + 1311) / 2622
  localparam int          LAT_START = 2621;
  localparam int          LAT_GAIN2 = 858;
  localparam int          LAT_BIAS  = 1311;
  localparam int          LAT_DEN   = 2622;
  localparam int          LAT_SHIFT = 35;
  localparam logic [23:0] LAT_RECIP = 24'((64'd1 << LAT_SHIFT) / LAT_DEN);

  // Working width of roll values after the margin clamp
  localparam int ROLL_W = 28;

  // Trig unit: fold, square, five Horner steps of three stages, output
  localparam int HORNER_STEPS = 5;
  localparam int TRIG_LAT     = 3 + 3 * HORNER_STEPS;

  // Horner divisors; chain 0 is cosine, chain 1 is sine
  function automatic int unsigned horner_div(input int ch, input int st);
    int unsigned n;
    n = 2;
    case (ch * HORNER_STEPS + st)
      0:       n = 90;
      1:       n = 56;
      2:       n = 30;
      3:       n = 12;
      4:       n = 2;
      5:       n = 110;
      6:       n = 72;
      7:       n = 42;
      8:       n = 20;
      9:       n = 6;
      default: n = 2;
    endcase
    return n;
  endfunction

  // Easing value (Q15) for a Q30 angle in [0, pi]; evaluated at elaboration
  function automatic logic [15:0] ease_of(input logic [63:0] t);
    logic [63:0] a;
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] rc;
    logic [63:0] num;
    logic        flip;
    a    = (t > PI_Q30) ? PI_Q30 : t;
    flip = (a > HALF_PI_Q30);
    if (flip) begin
      a = PI_Q30 - a;
    end
    u  = (a * a) >> 30;
    rc = Q30_ONE;
    x  = ((u * rc) >> 30) / 90;
    rc = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
    x  = ((u * rc) >> 30) / 56;
    rc = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
    x  = ((u * rc) >> 30) / 30;
    rc = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
    x  = ((u * rc) >> 30) / 12;
    rc = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
    x  = ((u * rc) >> 30) / 2;
    rc = (x > Q30_ONE) ? 64'd0 : Q30_ONE - x;
    num = flip ? (Q30_ONE + rc) : (Q30_ONE - rc);
    num = num >> 1;
    return 16'((num + 64'd16384) >> 15);
  endfunction

endpackage

// File: rtl/core/arm_swing_pose_generator_top.sv
// Arm swing pose generator: easing blend of arm poses with shoulder roll margins.
`timescale 1ns / 1ps

// Latency: an input beat reaches its first result beat through 24 pipeline stages plus
// the serializer register; six result beats follow on consecutive cycles when out_ready stays high.
// Throughput: set by the result channel carrying one joint per beat;
// the 24-stage pipeline takes a new item every cycle while the serializer has room.
// Reset: synchronous, active low; clears the valid pipeline, the serializer and the four
// arm pose registers to zero. The easing table is constant, so no clearing pass is needed.

module arm_swing_pose_generator_top #(
  parameter int SINE_TABLE_DEPTH = asp_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int ANGLE_WIDTH      = asp_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [15:0]                   in_phase,
  input  logic                          in_swing_is_left,
  input  logic signed [23:0]            in_left_foot_x,
  input  logic signed [23:0]            in_left_foot_y,
  input  logic signed [15:0]            in_left_foot_yaw,
  input  logic signed [23:0]            in_right_foot_x,
  input  logic signed [23:0]            in_right_foot_y,
  input  logic signed [15:0]            in_right_foot_yaw,
  input  logic signed [23:0]            in_torso_x,
  input  logic signed [23:0]            in_torso_y,
  input  logic signed [15:0]            in_torso_yaw,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_joint_select,
  output logic signed [15:0]            out_joint_angle,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [asp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asp_pkg::CFG_W-1:0]     cfg_data
);

  localparam int D    = SINE_TABLE_DEPTH;
  localparam int KW   = $clog2(D + 1);
  localparam int PW   = 17 + KW;
  localparam int KW0  = PW - 15;
  localparam int TL   = asp_pkg::TRIG_LAT;
  localparam int NSTG = TL + 6;
  localparam int RW   = asp_pkg::ROLL_W;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (ANGLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  typedef struct packed {
    logic [15:0]        e;
    logic [15:0]        ne;
    logic signed [24:0] dxl;
    logic signed [24:0] dyl;
    logic signed [24:0] dxr;
    logic signed [24:0] dyr;
    logic               tneg;
    logic [12:0]        lhalf;
    logic [12:0]        rhalf;
  } side_t;

  // Positive half of a yaw difference wrapped into [-pi, pi)
  function automatic logic [12:0] half_pos_rot(input logic signed [17:0] d);
    logic signed [17:0] w;
    w = d + 18'(asp_pkg::PI_Q12);
    if (w >= 18'(asp_pkg::TWO_PI_Q12)) w = w - 18'(asp_pkg::TWO_PI_Q12);
    if (w >= 18'(asp_pkg::TWO_PI_Q12)) w = w - 18'(asp_pkg::TWO_PI_Q12);
    if (w < 0) w = w + 18'(asp_pkg::TWO_PI_Q12);
    if (w < 0) w = w + 18'(asp_pkg::TWO_PI_Q12);
    w = w - 18'(asp_pkg::PI_Q12);
    return (w > 0) ? w[13:1] : 13'd0;
  endfunction

  // Saturate to the configured angle width, keep the low 16 bits
  function automatic logic [15:0] sat16(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[15:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [47:0] left_start_r, left_end_r, right_start_r, right_end_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_start_r  <= '0;
      left_end_r    <= '0;
      right_start_r <= '0;
      right_end_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        asp_pkg::REG_LEFT_START:  left_start_r  <= cfg_data;
        asp_pkg::REG_LEFT_END:    left_end_r    <= cfg_data;
        asp_pkg::REG_RIGHT_START: right_start_r <= cfg_data;
        asp_pkg::REG_RIGHT_END:   right_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic             vld_r [NSTG];
  logic             ser_vld_r;
  logic [2:0]       idx_r;
  logic             ser_load;
  logic             en;
  logic             out_fire;

  assign out_fire = ser_vld_r & out_ready;
  assign ser_load = vld_r[NSTG-1] & (~ser_vld_r | (out_fire & (idx_r == asp_pkg::JOINT_LAST)));
  assign en       = ~vld_r[NSTG-1] | ser_load;
  assign in_ready = en & rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NSTG; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int s = 1; s < NSTG; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // ---------------------------------------------------------------- easing table
  logic [15:0] ease_tab [D+1];

  for (genvar gi = 0; gi <= D; gi++) begin : g_ease
    localparam logic [63:0] TQ = (64'(gi) * asp_pkg::PI_Q30) / D;
    assign ease_tab[gi] = asp_pkg::ease_of(TQ);
  end

  // Phase to table index: round, wrap at two, fold about one
  logic [PW-1:0]  pd;
  logic [KW0-1:0] k0, k1, kf;
  logic [KW-1:0]  k_idx;

  always_comb begin
    pd    = PW'(in_phase) * PW'(D) + PW'(16384);
    k0    = pd[PW-1:15];
    k1    = (k0 >= KW0'(2 * D)) ? (k0 - KW0'(2 * D)) : k0;
    kf    = (k1 > KW0'(D)) ? (KW0'(2 * D) - k1) : k1;
    k_idx = kf[KW-1:0];
  end

  // Torso yaw wrapped into [-pi, pi)
  logic signed [16:0] t17;
  logic signed [15:0] tyw_nxt;

  always_comb begin
    t17 = 17'(in_torso_yaw);
    if (t17 >= 17'(asp_pkg::PI_Q12)) begin
      t17 = t17 - 17'(asp_pkg::TWO_PI_Q12);
    end else if (t17 < -17'(asp_pkg::PI_Q12)) begin
      t17 = t17 + 17'(asp_pkg::TWO_PI_Q12);
    end
    tyw_nxt = 16'(t17);
  end

  // ---------------------------------------------------------------- stage A
  logic [15:0]        ease_rd_r;
  logic               swing_a_r;
  logic signed [24:0] dxl_a_r, dyl_a_r, dxr_a_r, dyr_a_r;
  logic signed [15:0] lyaw_a_r, ryaw_a_r, tyw_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ease_rd_r <= ease_tab[k_idx];
      swing_a_r <= in_swing_is_left;
      dxl_a_r   <= 25'(in_left_foot_x) - 25'(in_torso_x);
      dyl_a_r   <= 25'(in_left_foot_y) - 25'(in_torso_y);
      dxr_a_r   <= 25'(in_right_foot_x) - 25'(in_torso_x);
      dyr_a_r   <= 25'(in_right_foot_y) - 25'(in_torso_y);
      lyaw_a_r  <= in_left_foot_yaw;
      ryaw_a_r  <= in_right_foot_yaw;
      tyw_a_r   <= tyw_nxt;
    end
  end

  // Torso trig angle: |yaw| moved from Q12 to Q30
  logic signed [15:0] tmag;
  logic [31:0]        trig_a;
  logic signed [31:0] trig_cos;
  logic [30:0]        trig_sin;

  assign tmag   = tyw_a_r[15] ? -tyw_a_r : tyw_a_r;
  assign trig_a = {tmag[13:0], 18'd0};

  asp_trig u_trig (
    .clk   (clk),
    .en    (en),
    .ang_i (trig_a),
    .cos_o (trig_cos),
    .sin_o (trig_sin)
  );

  // Side data delayed to meet the trig result
  side_t side_nxt;
  side_t side_r [TL];

  always_comb begin
    side_nxt.e     = swing_a_r ? (16'd32768 - ease_rd_r) : ease_rd_r;
    side_nxt.ne    = 16'd32768 - side_nxt.e;
    side_nxt.dxl   = dxl_a_r;
    side_nxt.dyl   = dyl_a_r;
    side_nxt.dxr   = dxr_a_r;
    side_nxt.dyr   = dyr_a_r;
    side_nxt.tneg  = tyw_a_r[15];
    side_nxt.lhalf = half_pos_rot(18'(lyaw_a_r) - 18'(tyw_a_r));
    side_nxt.rhalf = half_pos_rot(18'(tyw_a_r) - 18'(ryaw_a_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int s = 1; s < TL; s++) side_r[s] <= side_r[s-1];
    end
  end

  // ---------------------------------------------------------------- stage P: products
  side_t              sd;
  logic signed [31:0] ssin;
  logic signed [16:0] e17, ne17;

  assign sd   = side_r[TL-1];
  assign ssin = sd.tneg ? -$signed(32'(trig_sin)) : $signed(32'(trig_sin));
  assign e17  = $signed({1'b0, sd.e});
  assign ne17 = $signed({1'b0, sd.ne});

  logic signed [56:0] cl_p_r, sl_p_r, cr_p_r, sr_p_r;
  logic signed [32:0] pls_p_r [3];
  logic signed [32:0] ple_p_r [3];
  logic signed [32:0] prs_p_r [3];
  logic signed [32:0] pre_p_r [3];
  logic [12:0]        lhalf_p_r, rhalf_p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cl_p_r <= 57'(trig_cos) * 57'(sd.dyl);
      sl_p_r <= 57'(ssin) * 57'(sd.dxl);
      cr_p_r <= 57'(trig_cos) * 57'(sd.dyr);
      sr_p_r <= 57'(ssin) * 57'(sd.dxr);
      for (int j = 0; j < 3; j++) begin
        pls_p_r[j] <= e17 * $signed(left_start_r[16*j +: 16]);
        ple_p_r[j] <= ne17 * $signed(left_end_r[16*j +: 16]);
        prs_p_r[j] <= ne17 * $signed(right_start_r[16*j +: 16]);
        pre_p_r[j] <= e17 * $signed(right_end_r[16*j +: 16]);
      end
      lhalf_p_r <= sd.lhalf;
      rhalf_p_r <= sd.rhalf;
    end
  end

  // ---------------------------------------------------------------- stage Q: sums, rounding
  logic signed [57:0] ysl, ysr;
  logic signed [33:0] bsl [3];
  logic signed [33:0] bsr [3];

  always_comb begin
    ysl = 58'(cl_p_r) - 58'(sl_p_r) + 58'sd536870912;
    ysr = 58'(cr_p_r) - 58'(sr_p_r) + 58'sd536870912;
    for (int j = 0; j < 3; j++) begin
      bsl[j] = 34'(pls_p_r[j]) + 34'(ple_p_r[j]) + 34'sd16384;
      bsr[j] = 34'(prs_p_r[j]) + 34'(pre_p_r[j]) + 34'sd16384;
    end
  end

  logic signed [27:0] yl_q_r, yr_q_r;
  logic signed [18:0] la_q_r [3];
  logic signed [18:0] ra_q_r [3];
  logic [12:0]        lhalf_q_r, rhalf_q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      yl_q_r <= ysl[57:30];
      yr_q_r <= ysr[57:30];
      for (int j = 0; j < 3; j++) begin
        la_q_r[j] <= bsl[j][33:15];
        ra_q_r[j] <= bsr[j][33:15];
      end
      lhalf_q_r <= lhalf_p_r;
      rhalf_q_r <= rhalf_p_r;
    end
  end

  // ---------------------------------------------------------------- stage R: lateral excess
  logic signed [28:0] exl, exr;

  assign exl = 29'(yl_q_r) - 29'(asp_pkg::LAT_START);
  assign exr = -29'(yr_q_r) - 29'(asp_pkg::LAT_START);

  logic [34:0]        numl_r_r, numr_r_r;
  logic               posl_r_r, posr_r_r;
  logic signed [18:0] la_r_r [3];
  logic signed [18:0] ra_r_r [3];
  logic [12:0]        lhalf_r_r, rhalf_r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      numl_r_r  <= 35'(exl[27:0]) * 35'(asp_pkg::LAT_GAIN2) + 35'(asp_pkg::LAT_BIAS);
      numr_r_r  <= 35'(exr[27:0]) * 35'(asp_pkg::LAT_GAIN2) + 35'(asp_pkg::LAT_BIAS);
      posl_r_r  <= (exl > 0);
      posr_r_r  <= (exr > 0);
      la_r_r    <= la_q_r;
      ra_r_r    <= ra_q_r;
      lhalf_r_r <= lhalf_q_r;
      rhalf_r_r <= rhalf_q_r;
    end
  end

  // ---------------------------------------------------------------- stage S: reciprocal
  logic [58:0] mql, mqr;

  assign mql = 59'(numl_r_r) * 59'(asp_pkg::LAT_RECIP);
  assign mqr = 59'(numr_r_r) * 59'(asp_pkg::LAT_RECIP);

  logic [23:0]        ql0_s_r, qr0_s_r;
  logic [34:0]        numl_s_r, numr_s_r;
  logic               posl_s_r, posr_s_r;
  logic signed [18:0] la_s_r [3];
  logic signed [18:0] ra_s_r [3];
  logic [12:0]        lhalf_s_r, rhalf_s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ql0_s_r   <= mql[58:35];
      qr0_s_r   <= mqr[58:35];
      numl_s_r  <= numl_r_r;
      numr_s_r  <= numr_r_r;
      posl_s_r  <= posl_r_r;
      posr_s_r  <= posr_r_r;
      la_s_r    <= la_r_r;
      ra_s_r    <= ra_r_r;
      lhalf_s_r <= lhalf_r_r;
      rhalf_s_r <= rhalf_r_r;
    end
  end

  // ---------------------------------------------------------------- stage T: clamp, saturate
  logic [34:0]          reml, remr;
  logic [23:0]          ql, qr;
  logic signed [RW-1:0] lmin, rmin, lroll, rroll;
  logic [15:0]          ang_nxt [asp_pkg::NUM_JOINTS];

  always_comb begin
    reml = numl_s_r - 35'(ql0_s_r) * 35'(asp_pkg::LAT_DEN);
    remr = numr_s_r - 35'(qr0_s_r) * 35'(asp_pkg::LAT_DEN);
    ql   = ql0_s_r + ((reml >= 35'(asp_pkg::LAT_DEN)) ? 24'd1 : 24'd0);
    qr   = qr0_s_r + ((remr >= 35'(asp_pkg::LAT_DEN)) ? 24'd1 : 24'd0);
    lmin = RW'(asp_pkg::MIN_ROLL) + RW'(lhalf_s_r) + (posl_s_r ? RW'(ql) : RW'(0));
    rmin = -(RW'(asp_pkg::MIN_ROLL) + RW'(rhalf_s_r) + (posr_s_r ? RW'(qr) : RW'(0)));
    lroll = RW'(la_s_r[1]);
    if (lroll < lmin) lroll = lmin;
    rroll = RW'(ra_s_r[1]);
    if (rroll > rmin) rroll = rmin;
    ang_nxt[0] = sat16(RW'(ra_s_r[0]));
    ang_nxt[1] = sat16(rroll);
    ang_nxt[2] = sat16(RW'(ra_s_r[2]));
    ang_nxt[3] = sat16(RW'(la_s_r[0]));
    ang_nxt[4] = sat16(lroll);
    ang_nxt[5] = sat16(RW'(la_s_r[2]));
  end

  logic [15:0] ang_t_r [asp_pkg::NUM_JOINTS];

  always_ff @(posedge clk) begin
    if (en) begin
      ang_t_r <= ang_nxt;
    end
  end

  // ---------------------------------------------------------------- result serializer
  logic [15:0] ang_r [asp_pkg::NUM_JOINTS];

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ang_r <= ang_t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (ser_load) begin
      ser_vld_r <= 1'b1;
      idx_r     <= '0;
    end else if (out_fire) begin
      if (idx_r == asp_pkg::JOINT_LAST) begin
        ser_vld_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  assign out_valid        = ser_vld_r;
  assign out_joint_select = idx_r;
  assign out_joint_angle  = $signed(ang_r[idx_r]);
  assign out_last         = (idx_r == asp_pkg::JOINT_LAST);

endmodule

// File: rtl/core/asp_trig.sv
// Pipelined Q30 cosine and sine of an angle in [0, pi] by truncated Horner series.
`timescale 1ns / 1ps

module asp_trig (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        ang_i,
  output logic signed [31:0] cos_o,
  output logic [30:0]        sin_o
);

  localparam int NH = asp_pkg::HORNER_STEPS;
  localparam int LS = 1 + 3 * NH;
  localparam logic [31:0] PIQ  = 32'(asp_pkg::PI_Q30);
  localparam logic [31:0] HALF = 32'(asp_pkg::HALF_PI_Q30);
  localparam logic [31:0] ONE  = 32'(asp_pkg::Q30_ONE);

  logic [30:0] b_r    [0:LS];
  logic        flip_r [0:LS];
  logic [31:0] u_r    [1:LS-3];

  logic [31:0] v_r  [2][NH];
  logic [31:0] vh_r [2][NH];
  logic [31:0] q0_r [2][NH];
  logic [30:0] r_r  [2][NH];

  logic [31:0] a_clamp;
  logic        fold;
  logic [31:0] b_nxt;
  logic [61:0] bsq;
  logic [61:0] sprod;

  // Clamp to pi and fold into the first quadrant
  always_comb begin
    a_clamp = (ang_i > PIQ) ? PIQ : ang_i;
    fold    = (a_clamp > HALF);
    b_nxt   = fold ? (PIQ - a_clamp) : a_clamp;
  end

  assign bsq   = 62'(b_r[0]) * 62'(b_r[0]);
  assign sprod = 62'(b_r[LS]) * 62'(r_r[1][NH-1]);

  // Angle, fold flag and square travel along the stages
  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0]    <= b_nxt[30:0];
      flip_r[0] <= fold;
      u_r[1]    <= bsq[61:30];
      for (int s = 1; s <= LS; s++) begin
        b_r[s]    <= b_r[s-1];
        flip_r[s] <= flip_r[s-1];
      end
      for (int s = 2; s <= LS - 3; s++) begin
        u_r[s] <= u_r[s-1];
      end
    end
  end

  // Horner steps: multiply, reciprocal divide, correct and subtract from one
  for (genvar ch = 0; ch < 2; ch++) begin : g_chain
    for (genvar i = 0; i < NH; i++) begin : g_step
      localparam int unsigned N  = asp_pkg::horner_div(ch, i);
      localparam logic [31:0] MR = 32'((64'd1 << 32) / N);

      logic [30:0] r_in;
      logic [62:0] pr;
      logic [63:0] pm;
      logic [31:0] rem;
      logic [31:0] q;

      if (i == 0) begin : g_first
        assign r_in = ONE[30:0];
      end else begin : g_next
        assign r_in = r_r[ch][i-1];
      end

      assign pr  = 63'(u_r[1+3*i]) * 63'(r_in);
      assign pm  = 64'(v_r[ch][i]) * 64'(MR);
      assign rem = vh_r[ch][i] - q0_r[ch][i] * 32'(N);
      assign q   = q0_r[ch][i] + ((rem >= 32'(N)) ? 32'd1 : 32'd0);

      always_ff @(posedge clk) begin
        if (en) begin
          v_r[ch][i]  <= pr[61:30];
          q0_r[ch][i] <= pm[63:32];
          vh_r[ch][i] <= v_r[ch][i];
          r_r[ch][i]  <= (q > ONE) ? 31'd0 : 31'(ONE - q);
        end
      end
    end
  end

  // Unfold cosine, scale the sine polynomial by the angle
  always_ff @(posedge clk) begin
    if (en) begin
      cos_o <= flip_r[LS] ? -$signed(32'(r_r[0][NH-1])) : $signed(32'(r_r[0][NH-1]));
      sin_o <= sprod[60:30];
    end
  end

endmodule
